FILE: rtl/cedc_pkg.sv
// Shared types, constants and small helpers for the clock and environment display controller.
// Used by every module of the block; depends on nothing.
package cedc_pkg;

    // Command codes carried in the input beat
    localparam logic [2:0] CMD_SECOND  = 3'd0;
    localparam logic [2:0] CMD_REFRESH = 3'd1;
    localparam logic [2:0] CMD_MODE    = 3'd2;
    localparam logic [2:0] CMD_EDIT    = 3'd3;
    localparam logic [2:0] CMD_SENSOR  = 3'd4;

    // Display modes
    localparam logic [1:0] MODE_CLOCK  = 2'd0;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HB_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_BIT = 1'd1;
    localparam int unsigned CFG_DATA_W  = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] HB_PERIOD_RESET = 16'd500;
    localparam logic [3:0]  BLINK_BIT_RESET = 4'd6;

    // Key bits (active low on the pins)
    localparam int unsigned KEY_UP    = 0;
    localparam int unsigned KEY_DOWN  = 1;
    localparam int unsigned KEY_RIGHT = 2;
    localparam int unsigned KEY_LEFT  = 3;

    // Edit cursor fields
    localparam logic [1:0] CUR_HOUR   = 2'd0;
    localparam logic [1:0] CUR_MINUTE = 2'd1;
    localparam logic [1:0] CUR_SECOND = 2'd2;

    // Clock limits and reset time
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;
    localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
    localparam logic [5:0] SEC_PER_MIN   = 6'd60;
    localparam logic [4:0] HOUR_RESET    = 5'd12;
    localparam logic [5:0] MINUTE_RESET  = 6'd34;

    // Display geometry
    localparam int unsigned DIGIT_COUNT = 6;
    localparam logic [2:0]  LAST_DIGIT = 3'd5;

    // Glyph codes: 0..9 are decimal digits
    localparam logic [3:0] GLYPH_BLANK = 4'd10;
    localparam logic [3:0] GLYPH_MINUS = 4'd11;

    // Segment patterns (active low, bit 7 is the decimal point)
    localparam logic [7:0] SEG_BLANK  = 8'hFF;
    localparam logic [7:0] SEG_DP_ON  = 8'h7F;

    typedef struct packed {
        logic [2:0]        command;
        logic [3:0]        keys_raw;
        logic signed [7:0] sensor_value;
    } cedc_in_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [5:0] digit_select;
        logic       display_valid;
        logic       heartbeat;
        logic       request_valid;
        logic [1:0] request_code;
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic [1:0] mode_now;
        logic       editing;
        logic [1:0] cursor_now;
    } cedc_out_t;

    typedef struct packed {
        logic [15:0] heartbeat_period;
        logic [3:0]  blink_bit;
    } cedc_cfg_t;

    // What the digit renderer needs from the core
    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [7:0] reading;
        logic       edit;
        logic [1:0] cursor;
        logic [2:0] pos;
        logic       blink_on;
    } cedc_view_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } cedc_dec_t;

    // Seven-segment patterns for glyph codes 0..14
    function automatic logic [7:0] cedc_glyph_rom(input logic [3:0] code);
        logic [7:0] seg;
        begin
            unique case (code)
                4'd0:    seg = 8'hC0;
                4'd1:    seg = 8'hF9;
                4'd2:    seg = 8'hA4;
                4'd3:    seg = 8'hB0;
                4'd4:    seg = 8'h99;
                4'd5:    seg = 8'h92;
                4'd6:    seg = 8'h82;
                4'd7:    seg = 8'hF8;
                4'd8:    seg = 8'h80;
                4'd9:    seg = 8'h90;
                4'd10:   seg = 8'hFF;
                4'd11:   seg = 8'hBF;
                4'd12:   seg = 8'hC6;
                4'd13:   seg = 8'h8E;
                4'd14:   seg = 8'h8A;
                default: seg = SEG_BLANK;
            endcase
            return seg;
        end
    endfunction

    // Tens and ones of a value below 100, by a row of independent compares
    function automatic cedc_dec_t cedc_split(input logic [6:0] v);
        cedc_dec_t d;
        logic [6:0] t10;
        begin
            d.tens = '0;
            for (int i = 1; i < 10; i++) begin
                if (v >= 7'(i * 10))
                    d.tens = 4'(i);
            end
            t10 = 7'(d.tens) * 7'd10;
            d.ones = 4'(v - t10);
            return d;
        end
    endfunction

    // Increment with wrap at lim
    function automatic logic [5:0] cedc_step_up(input logic [5:0] v, input logic [5:0] lim);
        logic [5:0] nv;
        begin
            nv = v + 6'd1;
            return (nv >= lim) ? 6'd0 : nv;
        end
    endfunction

    // Decrement with wrap to lim-1
    function automatic logic [5:0] cedc_step_down(input logic [5:0] v, input logic [5:0] lim);
        begin
            return (v == 6'd0) ? (lim - 6'd1) : (v - 6'd1);
        end
    endfunction

endpackage

FILE: rtl/cedc_render.sv
// Digit renderer: picks the glyph for one display position and applies blink and colon dots.
// Depends on cedc_pkg.
module cedc_render
    import cedc_pkg::*;
(
    input  cedc_view_t view,
    output logic [7:0] segments
);

    logic       neg;
    logic [7:0] mag;
    logic       hund;
    logic [6:0] below_hund;
    cedc_dec_t  val_dec;
    logic [5:0] time_val;
    cedc_dec_t  time_dec;
    logic [3:0] glyph;
    logic       blinking;

    // Magnitude of the signed reading; -128 comes out as 128
    assign neg        = view.reading[7];
    assign mag        = neg ? (~view.reading + 8'd1) : view.reading;
    assign hund       = (mag >= 8'd100);
    assign below_hund = hund ? 7'(mag - 8'd100) : mag[6:0];
    assign val_dec    = cedc_split(below_hund);

    // Time digits: hh mm ss
    always_comb
    begin
        if (view.pos < 3'd2)
            time_val = {1'b0, view.hour};
        else if (view.pos < 3'd4)
            time_val = view.minute;
        else
            time_val = view.second;
    end
    assign time_dec = cedc_split({1'b0, time_val});

    // Glyph selection
    always_comb
    begin
        glyph = GLYPH_BLANK;
        if (view.mode == MODE_CLOCK)
        begin
            glyph = view.pos[0] ? time_dec.ones : time_dec.tens;
        end
        else
        begin
            unique case (view.pos)
                3'd0:    glyph = neg ? GLYPH_MINUS : (hund ? 4'd1 : GLYPH_BLANK);
                3'd1:    glyph = (mag >= 8'd10) ? val_dec.tens : GLYPH_BLANK;
                3'd2:    glyph = val_dec.ones;
                3'd5:    glyph = GLYPH_MINUS + {2'b00, view.mode};
                default: glyph = GLYPH_BLANK;
            endcase
        end
    end

    // Digits of the field under the edit cursor blink
    always_comb
    begin
        unique case (view.cursor)
            CUR_HOUR:   blinking = (view.pos < 3'd2);
            CUR_MINUTE: blinking = (view.pos == 3'd2) || (view.pos == 3'd3);
            default:    blinking = (view.pos >= 3'd4);
        endcase
        blinking = blinking && view.edit && (view.mode == MODE_CLOCK);
    end

    // Final pattern; colon dots on digits 2 and 4 while the seconds are odd
    always_comb
    begin
        segments = (blinking && view.blink_on) ? SEG_BLANK : cedc_glyph_rom(glyph);
        if ((view.mode == MODE_CLOCK) && ((view.pos == 3'd2) || (view.pos == 3'd4))
            && view.second[0])
            segments = segments & SEG_DP_ON;
    end

endmodule

FILE: rtl/cedc_in_stage.sv
// Input register of the controller: holds one accepted beat until the core takes it.
// Depends on cedc_pkg.
module cedc_in_stage
    import cedc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cedc_in_t in_data,
    input  logic     advance,
    output logic     st_valid,
    output cedc_in_t st_data
);

    logic     st_valid_reg;
    logic     st_valid_next;
    cedc_in_t st_data_reg;

    // Take a new beat when empty or when the held one moves on this cycle
    assign in_ready = !st_valid_reg || advance;

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (in_valid && in_ready)
            st_valid_next = 1'b1;
        else if (advance)
            st_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else
            st_valid_reg <= st_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            st_data_reg <= in_data;
    end

    assign st_valid = st_valid_reg;
    assign st_data  = st_data_reg;

endmodule

FILE: rtl/cedc_core.sv
// Controller core: clock, mode, edit cursor, reading, scan position and heartbeat state,
// and the result of one event. Depends on cedc_pkg and cedc_render.
module cedc_core
    import cedc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  cedc_in_t  item,
    input  cedc_cfg_t cfg,
    output cedc_out_t result
);

    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [1:0]  mode_reg, mode_next;
    logic        edit_reg, edit_next;
    logic [1:0]  cursor_reg, cursor_next;
    logic [7:0]  reading_reg, reading_next;
    logic [3:0]  prev_keys_reg, prev_keys_next;
    logic [2:0]  digit_index_reg, digit_index_next;
    logic [15:0] refresh_count_reg, refresh_count_next;
    logic [15:0] hb_count_reg, hb_count_next;
    logic        hb_level_reg, hb_level_next;

    // Key edge handling (used only by a refresh beat)
    logic [3:0] pressed;
    logic [1:0] cur_r, cur_rl;
    logic       key_up, key_dn;
    logic [5:0] ed_h_up, ed_m_up, ed_s_up;
    logic [5:0] ed_hour, ed_min, ed_sec;
    logic [15:0] hb_inc;
    logic       want_req;
    cedc_view_t view;
    logic [7:0] seg_draw;

    assign pressed = prev_keys_reg & ~item.keys_raw;
    assign key_up  = edit_reg && pressed[KEY_UP];
    assign key_dn  = edit_reg && pressed[KEY_DOWN];

    // Cursor moves: right, then left
    always_comb
    begin
        cur_r  = (edit_reg && pressed[KEY_RIGHT] && (cursor_reg < CUR_SECOND))
                 ? cursor_reg + 2'd1 : cursor_reg;
        cur_rl = (edit_reg && pressed[KEY_LEFT] && (cur_r > CUR_HOUR))
                 ? cur_r - 2'd1 : cur_r;
    end

    // Field steps: up, then down, on the field under the cursor
    always_comb
    begin
        ed_h_up = {1'b0, hour_reg};
        ed_m_up = minute_reg;
        ed_s_up = second_reg;
        if (key_up)
        begin
            unique case (cur_rl)
                CUR_HOUR:   ed_h_up = cedc_step_up({1'b0, hour_reg}, HOURS_PER_DAY);
                CUR_MINUTE: ed_m_up = cedc_step_up(minute_reg, MIN_PER_HOUR);
                default:    ed_s_up = cedc_step_up(second_reg, SEC_PER_MIN);
            endcase
        end
        ed_hour = ed_h_up;
        ed_min  = ed_m_up;
        ed_sec  = ed_s_up;
        if (key_dn)
        begin
            unique case (cur_rl)
                CUR_HOUR:   ed_hour = cedc_step_down(ed_h_up, HOURS_PER_DAY);
                CUR_MINUTE: ed_min  = cedc_step_down(ed_m_up, MIN_PER_HOUR);
                default:    ed_sec  = cedc_step_down(ed_s_up, SEC_PER_MIN);
            endcase
        end
    end

    // Digit drawn from the state after key handling
    always_comb
    begin
        view.mode     = mode_reg;
        view.hour     = ed_hour[4:0];
        view.minute   = ed_min;
        view.second   = ed_sec;
        view.reading  = reading_reg;
        view.edit     = edit_reg;
        view.cursor   = cur_rl;
        view.pos      = digit_index_reg;
        view.blink_on = refresh_count_reg[cfg.blink_bit];
    end

    cedc_render u_render (
        .view     (view),
        .segments (seg_draw)
    );

    assign hb_inc = hb_count_reg + 16'd1;

    // Next state and result of one event
    always_comb
    begin
        hour_next          = hour_reg;
        minute_next        = minute_reg;
        second_next        = second_reg;
        mode_next          = mode_reg;
        edit_next          = edit_reg;
        cursor_next        = cursor_reg;
        reading_next       = reading_reg;
        prev_keys_next     = prev_keys_reg;
        digit_index_next   = digit_index_reg;
        refresh_count_next = refresh_count_reg;
        hb_count_next      = hb_count_reg;
        hb_level_next      = hb_level_reg;
        want_req           = 1'b0;
        result.segments      = SEG_BLANK;
        result.digit_select  = '0;
        result.display_valid = 1'b0;

        unique case (item.command)
            CMD_SECOND:
            begin
                second_next = cedc_step_up(second_reg, SEC_PER_MIN);
                if (second_next == 6'd0)
                begin
                    want_req    = 1'b1;
                    minute_next = cedc_step_up(minute_reg, MIN_PER_HOUR);
                    if (minute_next == 6'd0)
                        hour_next = 5'(cedc_step_up({1'b0, hour_reg}, HOURS_PER_DAY));
                end
            end
            CMD_REFRESH:
            begin
                prev_keys_next     = item.keys_raw;
                hour_next          = ed_hour[4:0];
                minute_next        = ed_min;
                second_next        = ed_sec;
                cursor_next        = cur_rl;
                refresh_count_next = refresh_count_reg + 16'd1;
                result.segments      = seg_draw;
                result.digit_select  = 6'(1) << digit_index_reg;
                result.display_valid = 1'b1;
                digit_index_next = (digit_index_reg >= LAST_DIGIT) ? 3'd0
                                   : digit_index_reg + 3'd1;
                if (hb_inc >= cfg.heartbeat_period)
                begin
                    hb_count_next = '0;
                    hb_level_next = !hb_level_reg;
                end
                else
                begin
                    hb_count_next = hb_inc;
                end
            end
            CMD_MODE:
            begin
                mode_next = mode_reg + 2'd1;
                want_req  = 1'b1;
            end
            CMD_EDIT:
            begin
                edit_next = !edit_reg;
            end
            CMD_SENSOR:
            begin
                reading_next = item.sensor_value;
            end
            default:
            begin
            end
        endcase

        // A request in time mode is dropped
        result.request_valid = want_req && (mode_next != MODE_CLOCK);
        result.request_code  = result.request_valid ? (mode_next - 2'd1) : 2'd0;
        result.heartbeat     = hb_level_next;
        result.hour_now      = hour_next;
        result.minute_now    = minute_next;
        result.second_now    = second_next;
        result.mode_now      = mode_next;
        result.editing       = edit_next;
        result.cursor_now    = cursor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg          <= HOUR_RESET;
            minute_reg        <= MINUTE_RESET;
            second_reg        <= '0;
            mode_reg          <= MODE_CLOCK;
            edit_reg          <= 1'b0;
            cursor_reg        <= CUR_HOUR;
            reading_reg       <= '0;
            prev_keys_reg     <= '1;
            digit_index_reg   <= '0;
            refresh_count_reg <= '0;
            hb_count_reg      <= '0;
            hb_level_reg      <= 1'b0;
        end
        else if (advance)
        begin
            hour_reg          <= hour_next;
            minute_reg        <= minute_next;
            second_reg        <= second_next;
            mode_reg          <= mode_next;
            edit_reg          <= edit_next;
            cursor_reg        <= cursor_next;
            reading_reg       <= reading_next;
            prev_keys_reg     <= prev_keys_next;
            digit_index_reg   <= digit_index_next;
            refresh_count_reg <= refresh_count_next;
            hb_count_reg      <= hb_count_next;
            hb_level_reg      <= hb_level_next;
        end
    end

`ifndef SYNTHESIS
    // Scan position never leaves the six digits
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_index_reg <= LAST_DIGIT)
        else $error("digit index out of range");

    // Clock fields stay in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hour_reg < 5'(HOURS_PER_DAY)) && (minute_reg < MIN_PER_HOUR)
        && (second_reg < SEC_PER_MIN))
        else $error("clock field out of range");

    // Cursor only names hours, minutes or seconds
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CUR_SECOND)
        else $error("cursor out of range");
`endif

endmodule

FILE: rtl/clock_env_display_controller_unit.sv
// Top level of the clock and environment display controller: config registers,
// input register, core and result register. Depends on cedc_pkg, cedc_in_stage, cedc_core.
//
//  Channel  Handshake              Payload       Notes
//  in       in_valid / in_ready    in_data       one event per beat
//  out      out_valid / out_ready  out_data      one result per event
//  cfg      cfg_we                 cfg_index,    0 heartbeat_period, 1 blink_bit
//                                  cfg_data
//
// One event per clock while out_ready stays high; an accepted beat is held in the input register,
// then passes through the core logic into the result register.
// While a finished result waits on out_ready, the input register holds one more beat and
// then in_ready drops until the result is taken.
// Reset: time 12:34:00, time mode, not editing, keys released, heartbeat period 500,
// blink bit 6.
module clock_env_display_controller_unit
    import cedc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cedc_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cedc_out_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cedc_cfg_t cfg_reg;
    logic      st_valid;
    cedc_in_t  st_data;
    logic      advance;
    cedc_out_t result;
    logic      out_valid_reg;
    logic      out_valid_next;
    cedc_out_t out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heartbeat_period <= HB_PERIOD_RESET;
            cfg_reg.blink_bit        <= BLINK_BIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HB_PERIOD: cfg_reg.heartbeat_period <= cfg_data;
                default:       cfg_reg.blink_bit        <= cfg_data[3:0];
            endcase
        end
    end

    // The held beat moves when the result slot is free or being emptied
    assign advance = st_valid && (!out_valid_reg || out_ready);

    cedc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .advance  (advance),
        .st_valid (st_valid),
        .st_data  (st_data)
    );

    cedc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (st_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A drawn digit enables exactly one digit; otherwise the display fields are idle
    a_digit_select: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.display_valid ? $onehot(out_data.digit_select)
                       : ((out_data.digit_select == '0) && (out_data.segments == SEG_BLANK))))
        else $error("digit select inconsistent with display_valid");

    // A request names the unit of the current value mode
    a_request_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.request_valid) |->
        ((out_data.mode_now != MODE_CLOCK)
         && (out_data.request_code == out_data.mode_now - 2'd1)))
        else $error("request code does not match mode");

    // A held input beat that cannot move is still held next cycle
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid && !advance) |=> st_valid)
        else $error("input beat lost while stalled");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for clock_env_display_controller_unit: directed table plus
// random event streams, every result beat checked against a cycle-free display predictor.
// Depends on cedc_pkg and the block's RTL.
module tb_top;
    import cedc_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
    localparam logic [3:0] KEYS_RELEASED = 4'hF;
    localparam int         N_PHASES      = 6;
    localparam int         PHASE_BEATS   = 235;
    localparam int         CYCLE_LIMIT   = 200000;

    // One stimulus row: the event, plus an optional hand-written display expectation
    typedef struct packed {
        cedc_in_t   ev;
        logic       typed;
        logic [7:0] seg;
        logic [5:0] sel;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    cedc_in_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    cedc_out_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    clock_env_display_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted block state
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [1:0]  disp_mode;
    logic        edit_on;
    logic [1:0]  cur_field;
    logic [7:0]  last_reading;
    logic [3:0]  last_keys;
    logic [2:0]  scan_pos;
    logic [15:0] refresh_cnt;
    logic [15:0] hb_cnt;
    logic        hb_level;
    logic [15:0] hb_period;
    logic [3:0]  blink_sel;

    cedc_out_t   awaited_frames[$];
    stim_row_t   directed_rows[$];
    int          beats_sent;
    int          fail_count;
    int          cycle_count;
    bit          steady;

    function automatic void reset_display_model();
        hh           = HOUR_RESET;
        mm           = MINUTE_RESET;
        ss           = '0;
        disp_mode    = MODE_CLOCK;
        edit_on      = 1'b0;
        cur_field    = CUR_HOUR;
        last_reading = '0;
        last_keys    = KEYS_RELEASED;
        scan_pos     = '0;
        refresh_cnt  = '0;
        hb_cnt       = '0;
        hb_level     = 1'b0;
        hb_period    = HB_PERIOD_RESET;
        blink_sel    = BLINK_BIT_RESET;
    endfunction

    function automatic int wrap_up(input int v, input int lim);
        return (v + 1 >= lim) ? 0 : v + 1;
    endfunction

    function automatic int wrap_down(input int v, input int lim);
        return (v == 0) ? lim - 1 : v - 1;
    endfunction

    // Step the field under the edit cursor
    function automatic void step_field(input bit up);
        case (cur_field)
            CUR_HOUR:
                hh = 5'(up ? wrap_up(hh, HOURS_PER_DAY) : wrap_down(hh, HOURS_PER_DAY));
            CUR_MINUTE:
                mm = 6'(up ? wrap_up(mm, MIN_PER_HOUR) : wrap_down(mm, MIN_PER_HOUR));
            default:
                ss = 6'(up ? wrap_up(ss, SEC_PER_MIN) : wrap_down(ss, SEC_PER_MIN));
        endcase
    endfunction

    // Common-anode patterns: digits, blank, minus, then C F H
    function automatic logic [7:0] font_pattern(input int g);
        case (g)
            0:           return 8'hC0;
            1:           return 8'hF9;
            2:           return 8'hA4;
            3:           return 8'hB0;
            4:           return 8'h99;
            5:           return 8'h92;
            6:           return 8'h82;
            7:           return 8'hF8;
            8:           return 8'h80;
            9:           return 8'h90;
            GLYPH_MINUS: return 8'hBF;
            12:          return 8'hC6;
            13:          return 8'h8E;
            14:          return 8'h8A;
            default:     return SEG_BLANK;
        endcase
    endfunction

    // Glyph shown at a digit position for the current mode
    function automatic int glyph_for(input int pos);
        int  v;
        int  mag;
        bit  neg;
        if (disp_mode == MODE_CLOCK) begin
            v = (pos < 2) ? hh : (pos < 4) ? mm : ss;
            return (pos % 2 == 1) ? v % 10 : (v / 10) % 10;
        end
        // -128 comes out as magnitude 128; its hundreds digit is never shown
        neg = last_reading[7];
        mag = neg ? 256 - int'(last_reading) : int'(last_reading);
        case (pos)
            0:       return neg ? int'(GLYPH_MINUS)
                                : (mag >= 100) ? (mag / 100) % 10 : int'(GLYPH_BLANK);
            1:       return (mag >= 10) ? (mag / 10) % 10 : int'(GLYPH_BLANK);
            2:       return mag % 10;
            5:       return int'(GLYPH_MINUS) + int'(disp_mode);
            default: return GLYPH_BLANK;
        endcase
    endfunction

    // Apply one event to the predicted state and return the status beat it yields
    function automatic cedc_out_t run_display_event(input cedc_in_t ev);
        cedc_out_t  r;
        logic [3:0] hit;
        int         pos;
        bit         ask;
        bit         blink_field;
        r          = '0;
        r.segments = SEG_BLANK;
        ask        = 1'b0;
        case (ev.command)
            CMD_SECOND:
            begin
                ss = 6'(wrap_up(ss, SEC_PER_MIN));
                if (ss == 0)
                begin
                    ask = 1'b1;
                    mm  = 6'(wrap_up(mm, MIN_PER_HOUR));
                    if (mm == 0)
                        hh = 5'(wrap_up(hh, HOURS_PER_DAY));
                end
            end
            CMD_REFRESH:
            begin
                // falling key edges act in order right, left, up, down
                hit       = last_keys & ~ev.keys_raw;
                last_keys = ev.keys_raw;
                if (edit_on)
                begin
                    if (hit[KEY_RIGHT] && cur_field < CUR_SECOND)
                        cur_field = cur_field + 2'd1;
                    if (hit[KEY_LEFT] && cur_field > CUR_HOUR)
                        cur_field = cur_field - 2'd1;
                    if (hit[KEY_UP])
                        step_field(1'b1);
                    if (hit[KEY_DOWN])
                        step_field(1'b0);
                end
                if (scan_pos >= DIGIT_COUNT)
                    scan_pos = '0;
                pos = scan_pos;
                blink_field = (disp_mode == MODE_CLOCK) && edit_on &&
                              ((cur_field == CUR_HOUR)   ? (pos < 2) :
                               (cur_field == CUR_MINUTE) ? (pos == 2 || pos == 3) :
                                                           (pos >= 4));
                // blink phase uses the count before this refresh bumps it
                if (blink_field && refresh_cnt[blink_sel])
                    r.segments = SEG_BLANK;
                else
                    r.segments = font_pattern(glyph_for(pos));
                refresh_cnt = refresh_cnt + 16'd1;
                // colon dots on odd seconds, blanked digits included
                if (disp_mode == MODE_CLOCK && (pos == 2 || pos == 4) && ss[0])
                    r.segments = r.segments & SEG_DP_ON;
                r.digit_select  = 6'(1 << pos);
                r.display_valid = 1'b1;
                scan_pos = (pos == LAST_DIGIT) ? 3'd0 : 3'(pos + 1);
                hb_cnt = hb_cnt + 16'd1;
                if (hb_cnt >= hb_period)
                begin
                    hb_cnt   = '0;
                    hb_level = ~hb_level;
                end
            end
            CMD_MODE:
            begin
                disp_mode = disp_mode + 2'd1;
                ask       = 1'b1;
            end
            CMD_EDIT:
                edit_on = ~edit_on;
            CMD_SENSOR:
                last_reading = ev.sensor_value;
            default:
                ;
        endcase
        // requests made in time mode are dropped
        if (ask && disp_mode != MODE_CLOCK)
        begin
            r.request_valid = 1'b1;
            r.request_code  = disp_mode - 2'd1;
        end
        r.heartbeat  = hb_level;
        r.hour_now   = hh;
        r.minute_now = mm;
        r.second_now = ss;
        r.mode_now   = disp_mode;
        r.editing    = edit_on;
        r.cursor_now = cur_field;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_frame(input cedc_out_t want, input cedc_out_t got);
        check_field("segments",      want.segments,      got.segments);
        check_field("digit_select",  want.digit_select,  got.digit_select);
        check_field("display_valid", want.display_valid, got.display_valid);
        check_field("heartbeat",     want.heartbeat,     got.heartbeat);
        check_field("request_valid", want.request_valid, got.request_valid);
        check_field("request_code",  want.request_code,  got.request_code);
        check_field("hour_now",      want.hour_now,      got.hour_now);
        check_field("minute_now",    want.minute_now,    got.minute_now);
        check_field("second_now",    want.second_now,    got.second_now);
        check_field("mode_now",      want.mode_now,      got.mode_now);
        check_field("editing",       want.editing,       got.editing);
        check_field("cursor_now",    want.cursor_now,    got.cursor_now);
    endfunction

    function automatic void add_row(input logic [2:0] cmd, input logic [3:0] keys,
                                    input logic [7:0] sval, input logic typed,
                                    input logic [7:0] seg, input logic [5:0] sel);
        stim_row_t row;
        row.ev.command      = cmd;
        row.ev.keys_raw     = keys;
        row.ev.sensor_value = sval;
        row.typed           = typed;
        row.seg             = seg;
        row.sel             = sel;
        directed_rows.push_back(row);
    endfunction

    // Sensor byte, biased toward the display corner cases
    function automatic logic [7:0] pick_reading();
        if ($urandom_range(0, 9) >= 3)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       return 8'h80;
            1:       return 8'hFF;
            2:       return 8'h00;
            3:       return 8'd9;
            4:       return 8'd10;
            5:       return 8'd99;
            6:       return 8'd100;
            7:       return 8'h7F;
            8:       return 8'h9C;
            default: return 8'h9D;
        endcase
    endfunction

    function automatic stim_row_t make_event(input logic [2:0] cmd, input logic [3:0] keys);
        stim_row_t row;
        row                 = '0;
        row.ev.command      = cmd;
        row.ev.keys_raw     = keys;
        row.ev.sensor_value = pick_reading();
        return row;
    endfunction

    function automatic stim_row_t random_event();
        int         roll;
        logic [2:0] cmd;
        logic [3:0] keys;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            cmd = CMD_SECOND;
        else if (roll < 70)
            cmd = CMD_REFRESH;
        else if (roll < 78)
            cmd = CMD_MODE;
        else if (roll < 84)
            cmd = CMD_EDIT;
        else if (roll < 95)
            cmd = CMD_SENSOR;
        else
            cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        keys = ($urandom_range(0, 1) == 0) ? KEYS_RELEASED : 4'($urandom_range(0, 15));
        return make_event(cmd, keys);
    endfunction

    function automatic cedc_cfg_t phase_setting(input int p);
        case (p)
            0:       return {16'd1, 4'd0};
            1:       return {16'd0, 4'd15};
            2:       return {16'd65535, 4'd3};
            3:       return {16'd3, 4'd1};
            4:       return {16'd7, 4'd2};
            default: return {16'd2, 4'd0};
        endcase
    endfunction

    // Present one input beat; entered and left just after a falling edge
    task automatic send_item(input stim_row_t row);
        cedc_out_t want;
        while (!steady && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= row.ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = run_display_event(row.ev);
        if (row.typed)
        begin
            want.segments     = row.seg;
            want.digit_select = row.sel;
        end
        awaited_frames.push_back(want);
        beats_sent++;
        @(negedge clk);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_frames.size() != 0);
    endtask

    task automatic configure(input cedc_cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HB_PERIOD;
        cfg_data  <= c.heartbeat_period;
        @(negedge clk);
        cfg_index <= CFG_BLINK_BIT;
        cfg_data  <= CFG_DATA_W'(c.blink_bit);
        @(negedge clk);
        cfg_we    <= 1'b0;
        hb_period = c.heartbeat_period;
        blink_sel = c.blink_bit;
    endtask

    // A clean key press: release first if needed, then one falling edge
    task automatic press_key(input int unsigned k);
        if (last_keys != KEYS_RELEASED)
            send_item(make_event(CMD_REFRESH, KEYS_RELEASED));
        send_item(make_event(CMD_REFRESH, ~(4'b0001 << k)));
    endtask

    task automatic tick_seconds(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(make_event(CMD_REFRESH, KEYS_RELEASED));
            else
                send_item(make_event(CMD_SECOND, KEYS_RELEASED));
        end
    endtask

    // Random presses while editing, mostly in time mode so blinking shows
    task automatic edit_session();
        if ($urandom_range(0, 9) < 7)
            while (disp_mode != MODE_CLOCK)
                send_item(make_event(CMD_MODE, KEYS_RELEASED));
        if (!edit_on)
            send_item(make_event(CMD_EDIT, KEYS_RELEASED));
        repeat ($urandom_range(2, 20))
            press_key($urandom_range(0, 3));
        repeat ($urandom_range(0, 16))
            send_item(make_event(CMD_REFRESH, KEYS_RELEASED));
        if ($urandom_range(0, 4) != 0)
            send_item(make_event(CMD_EDIT, KEYS_RELEASED));
    endtask

    // Walk the clock to a target time with the keys, shortest way per field
    task automatic set_clock_to(input int th, input int tm, input int ts);
        int cur_v;
        int lim;
        int goal;
        int steps;
        if (!edit_on)
            send_item(make_event(CMD_EDIT, KEYS_RELEASED));
        while (cur_field != CUR_HOUR)
            press_key(KEY_LEFT);
        for (int f = 0; f < 3; f++)
        begin
            cur_v = (f == 0) ? int'(hh) : (f == 1) ? int'(mm) : int'(ss);
            lim   = (f == 0) ? int'(HOURS_PER_DAY) : int'(MIN_PER_HOUR);
            goal  = (f == 0) ? th : (f == 1) ? tm : ts;
            steps = (goal - cur_v + lim) % lim;
            if (steps <= lim / 2)
                repeat (steps) press_key(KEY_UP);
            else
                repeat (lim - steps) press_key(KEY_DOWN);
            if (f < 2)
                press_key(KEY_RIGHT);
        end
        send_item(make_event(CMD_EDIT, KEYS_RELEASED));
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side stalls
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 15);

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_frames.size() == 0)
            begin
                $error("result beat with no expectation pending");
                fail_count++;
            end
            else
                compare_frame(awaited_frames.pop_front(), out_data);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[clock_env_display_controller_unit] ERROR");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int stop_at;
        int roll;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        beats_sent  = 0;
        fail_count  = 0;
        cycle_count = 0;
        steady      = 1'b0;
        reset_display_model();

        // From reset: 12:34:00, time mode, reading 0
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hF9, 6'h01);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hA4, 6'h02);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hB0, 6'h04);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'h99, 6'h08);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hC0, 6'h10);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hC0, 6'h20);
        add_row(CMD_SECOND,  4'hF, 8'h00, 1'b1, 8'hFF, 6'h00);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b0, 8'h00, 6'h00);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b0, 8'h00, 6'h00);
        // odd second: colon dot on digit 2
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'h30, 6'h04);
        // most negative reading, then Celsius: shows "-28" and C
        add_row(CMD_SENSOR,  4'hF, 8'h80, 1'b1, 8'hFF, 6'h00);
        add_row(CMD_MODE,    4'hF, 8'h00, 1'b1, 8'hFF, 6'h00);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hFF, 6'h08);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hFF, 6'h10);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hC6, 6'h20);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hBF, 6'h01);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'hA4, 6'h02);
        add_row(CMD_REFRESH, 4'hF, 8'h00, 1'b1, 8'h80, 6'h04);
        add_row(CMD_SENSOR,  4'hF, 8'h7F, 1'b0, 8'h00, 6'h00);
        // walk F, H and back to time, where the request is dropped
        add_row(CMD_MODE,    4'hF, 8'h00, 1'b0, 8'h00, 6'h00);
        add_row(CMD_MODE,    4'hF, 8'h00, 1'b0, 8'h00, 6'h00);
        add_row(CMD_MODE,    4'hF, 8'h00, 1'b0, 8'h00, 6'h00);
        // every key falls at once while editing
        add_row(CMD_EDIT,    4'hF, 8'h00, 1'b0, 8'h00, 6'h00);
        add_row(CMD_REFRESH, 4'h0, 8'h00, 1'b0, 8'h00, 6'h00);
        add_row(CMD_SPARE_HI, 4'h0, 8'h80, 1'b0, 8'h00, 6'h00);
        add_row(CMD_EDIT,    4'hF, 8'hFF, 1'b0, 8'h00, 6'h00);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // Random phases, each under a new register setting
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            configure(phase_setting(p));
            steady  = (p == 2);
            stop_at = beats_sent + PHASE_BEATS;
            while (beats_sent < stop_at)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    if ($urandom_range(0, 1) == 0)
                        set_clock_to(23, 59, $urandom_range(50, 59));
                    else
                        set_clock_to($urandom_range(0, 23), $urandom_range(0, 59),
                                     $urandom_range(0, 59));
                    tick_seconds($urandom_range(10, 70));
                end
                else if (roll < 12)
                begin
                    edit_session();
                    tick_seconds($urandom_range(0, 20));
                end
                else
                    send_item(random_event());
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[clock_env_display_controller_unit] OK");
        else
            $display("[clock_env_display_controller_unit] ERROR");
        $finish;
    end

endmodule
